// ----- rtl/cndt_pkg.sv -----
// Shared types, constants and helper functions of the node discovery table.
`default_nettype none

package cndt_pkg;

   // Table geometry.
   localparam int TYPE_COUNT     = 8;
   localparam int IDS_PER_TYPE   = 7;
   localparam int TYPE_IDX_W     = $clog2(TYPE_COUNT);

   // Field widths fixed by the frame decoder.
   localparam int NODE_CLASS_W   = 3;
   localparam int NODE_NUM_W     = 8;
   localparam int CNT_W          = 3;
   localparam int COMPARED_TYPES = 7;

   // A row never holds more entries than the count can express.
   localparam int ROW_CAP_INT = (IDS_PER_TYPE < 7) ? IDS_PER_TYPE : 7;
   localparam logic [CNT_W-1:0] ROW_CAP = CNT_W'(ROW_CAP_INT);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Frame kinds.
   localparam logic KIND_WAKEUP = 1'b0;
   localparam logic KIND_OTHER  = 1'b1;

   // One row of the identifier store.
   localparam int ROW_W = IDS_PER_TYPE * NODE_NUM_W;
   typedef logic [IDS_PER_TYPE-1:0][NODE_NUM_W-1:0] id_row_type;

   // Per-type counters and expected counts.
   typedef logic [TYPE_COUNT-1:0][CNT_W-1:0]     count_array_type;
   typedef logic [COMPARED_TYPES-1:0][CNT_W-1:0] expect_array_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      logic                  wakeup;    // wake-up frame for a type that has a row
      logic                  in_table;  // node type has a row
      logic [TYPE_IDX_W-1:0] row;
      logic [NODE_NUM_W-1:0] node_number;
   } cmd_type;

   // Head of the queue as seen by the back part.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // Row index of a node type; only meaningful when the type is in the table.
   function automatic logic [TYPE_IDX_W-1:0] type_row(input logic [NODE_CLASS_W-1:0] t);
      int unsigned v;
      v = int'(t);
      return TYPE_IDX_W'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cndt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cndt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cndt_front.sv -----
// Front part: accepts requests, classifies them and queues the commands.
`default_nettype none

module cndt_front
   import cndt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [NODE_CLASS_W-1:0] req_node_class,
   input  wire logic [NODE_NUM_W-1:0]   req_node_number,
   output queue_head_type               head,
   input  wire logic                    pop
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   push;
   cmd_type                cmd_new;
   logic                   in_table;

   // Classify the incoming request.
   always_comb begin
      in_table            = (int'(req_node_class) < TYPE_COUNT);
      cmd_new.in_table    = in_table;
      cmd_new.wakeup      = in_table && (req_kind == KIND_WAKEUP);
      cmd_new.row         = type_row(req_node_class);
      cmd_new.node_number = req_node_number;
   end

   // Queue handshake.
   assign req_stall  = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH-1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH-1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cndt_back.sv -----
// Back part: row lookup and append, per-type counts and the completion check.
`default_nettype none

module cndt_back
   import cndt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_head_type   head,
   output logic                  pop,
   input  wire expect_array_type expect_cnt,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_added,
   output logic                  rsp_duplicate,
   output logic                  rsp_list_full,
   output logic      [CNT_W-1:0] rsp_type_count,
   output logic                  rsp_all_detected
);

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'b01,
      BACK_CHECK = 2'b10
   } back_state_type;

   back_state_type  state_ff, state_in;
   cmd_type         cmd_ff;
   count_array_type counts_ff, counts_in;
   logic            done_ff, done_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            added_ff, added_in;
   logic            dup_ff, dup_in;
   logic            full_ff, full_in;
   logic [CNT_W-1:0] tcount_ff, tcount_in;

   logic [ROW_W-1:0] rd_data;
   id_row_type       row_old;
   id_row_type       row_new;
   logic             wr_en;
   logic [CNT_W-1:0] cnt;
   logic             match;
   logic             all_match;

   assign row_old = id_row_type'(rd_data);

   // Identifier rows, one per node type.
   cndt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TYPE_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.row),
      .wr_data (ROW_W'(row_new)),
      .rd_en   (pop),
      .rd_addr (head.cmd.row),
      .rd_data (rd_data)
   );

   // Take a command only when the result register will be free for it.
   assign pop = (state_ff == BACK_IDLE) && head.valid && (!rsp_valid_ff || !rsp_stall);

   // Search the listed entries of the row and build the appended row.
   always_comb begin
      cnt     = counts_ff[cmd_ff.row];
      match   = 1'b0;
      row_new = row_old;
      for (int i = 0; i < IDS_PER_TYPE; i++) begin
         if (i < int'(cnt) && row_old[i] == cmd_ff.node_number) begin
            match = 1'b1;
         end
         if (i == int'(cnt)) begin
            row_new[i] = cmd_ff.node_number;
         end
      end
   end

   // Sequencer, count update, completion check and result register.
   always_comb begin
      state_in     = state_ff;
      counts_in    = counts_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      added_in     = added_ff;
      dup_in       = dup_ff;
      full_in      = full_ff;
      tcount_in    = tcount_ff;
      wr_en        = 1'b0;
      all_match    = 1'b1;

      unique case (state_ff)
         BACK_IDLE: begin
            if (pop) begin
               state_in = BACK_CHECK;
            end
         end
         BACK_CHECK: begin
            added_in = 1'b0;
            dup_in   = 1'b0;
            full_in  = 1'b0;
            if (cmd_ff.wakeup) begin
               if (match) begin
                  dup_in = 1'b1;
               end else if (cnt < ROW_CAP) begin
                  added_in              = 1'b1;
                  wr_en                 = 1'b1;
                  counts_in[cmd_ff.row] = cnt + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            tcount_in = cmd_ff.in_table ? counts_in[cmd_ff.row] : '0;

            // Compare every checked type; a type without a row counts as zero.
            for (int c = 0; c < COMPARED_TYPES; c++) begin
               if (c < TYPE_COUNT) begin
                  if (counts_in[TYPE_IDX_W'(c)] != expect_cnt[c]) begin
                     all_match = 1'b0;
                  end
               end else if (expect_cnt[c] != '0) begin
                  all_match = 1'b0;
               end
            end
            if (all_match) begin
               done_in = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         counts_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and result payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head.cmd;
      end
      added_ff  <= added_in;
      dup_ff    <= dup_in;
      full_ff   <= full_in;
      tcount_ff <= tcount_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_added        = added_ff;
   assign rsp_duplicate    = dup_ff;
   assign rsp_list_full    = full_ff;
   assign rsp_type_count   = tcount_ff;
   assign rsp_all_detected = done_ff;

endmodule

`default_nettype wire

// ----- rtl/can_node_discovery_table.sv -----
// Top level of the bus node discovery table with its expected-count registers.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  kind, node_class, node_number
//   rsp_     out        rsp_valid / rsp_stall  added, duplicate, list_full,
//                                              type_count, all_detected
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// In the back part each request first reads its type's row from the row RAM,
// then is compared, appended and counted before the next request is taken.
// With an empty queue and an idle back part, a request passes through the
// queue, the row read and the check before its response is registered.
// A two-entry queue lets requests be accepted while the back part is busy or
// the result register waits on rsp_stall.
// Synchronous reset clears counts, the all-detected flag and the expected
// counts; row RAM entries beyond a type's count are never compared.
`default_nettype none

module can_node_discovery_table
   import cndt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [NODE_CLASS_W-1:0] req_node_class,
   input  wire logic [NODE_NUM_W-1:0]   req_node_number,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_added,
   output logic                         rsp_duplicate,
   output logic                         rsp_list_full,
   output logic      [CNT_W-1:0]        rsp_type_count,
   output logic                         rsp_all_detected,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   expect_array_type expect_ff, expect_in;
   queue_head_type   head;
   logic             pop;

   // Expected-count registers; writes past the last register are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      expect_in = expect_ff;
      if (csr_valid && csr_ready && int'(csr_index) < COMPARED_TYPES) begin
         expect_in[csr_index] = csr_wdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
      end else begin
         expect_ff <= expect_in;
      end
   end

   // Request intake and command queue.
   cndt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_node_class  (req_node_class),
      .req_node_number (req_node_number),
      .head            (head),
      .pop             (pop)
   );

   // Table update and result generation.
   cndt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .expect_cnt       (expect_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_added        (rsp_added),
      .rsp_duplicate    (rsp_duplicate),
      .rsp_list_full    (rsp_list_full),
      .rsp_type_count   (rsp_type_count),
      .rsp_all_detected (rsp_all_detected)
   );

endmodule

`default_nettype wire
